[rtl/ddo_pkg.sv]
// Shared constants, command and status types and the arctangent table of the odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TRAVEL_WIDTH = 24;
  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam int SUM_W = (TRAVEL_WIDTH + 3 > 34) ? TRAVEL_WIDTH + 3 : 34;

  localparam logic [31:0] APD_RESET = 32'd3417826378;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_SET = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_HOLD = 2'd3;

  localparam logic [1:0] MUL_ANG = 2'd0;
  localparam logic [1:0] MUL_X = 2'd1;
  localparam logic [1:0] MUL_Y = 2'd2;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic [1:0] mul_sel;
    logic cordic_init;
    logic cordic_step;
    logic [ITER_W-1:0] iter;
    logic take_ang;
    logic acc_x;
    logic acc_y;
    logic commit;
  } ddo_cmd_t;

  typedef struct packed {
    logic is_update;
  } ddo_stat_t;

  function automatic logic [29:0] atan_at(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/ddo_in_if.sv]
// Input channel interface carrying one command word of the odometry block.
interface ddo_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] left_travel;
  logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] right_travel;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_heading;

  modport source (
    output valid, func, left_travel, right_travel, new_x, new_y, new_heading,
    input ready
  );
  modport sink (
    input valid, func, left_travel, right_travel, new_x, new_y, new_heading,
    output ready
  );
endinterface

[rtl/ddo_out_if.sv]
// Result channel interface carrying one pose word of the odometry block.
interface ddo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;
  logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] last_linear;
  logic signed [31:0] last_angular;

  modport source (
    output valid, pose_x, pose_y, pose_heading, last_linear, last_angular,
    input ready
  );
  modport sink (
    input valid, pose_x, pose_y, pose_heading, last_linear, last_angular,
    output ready
  );
endinterface

[rtl/diff_drive_odometry.sv]
// Top level of the differential-drive odometry block.
// The block keeps a robot pose (x, y, heading) and advances it from wheel travel.
// Input words arrive on in_ch: func selects update from left/right travel, set
// pose from new_x/new_y/new_heading, or clear of pose and history. Every input
// word yields exactly one result word on out_ch with the pose after the word
// and the linear and angular steps of the last update.
// An update forms the angular step on the shared multiplier, runs the iterative
// CORDIC of CORDIC_STEPS iterations, then multiplies and accumulates x and y;
// set, clear and the unused code go straight to the result. A new word is
// accepted only once the controller is idle again after the previous result
// is registered, so the block takes no new word while one is in flight.
// The result register holds a finished word while the receiver stalls; the
// next input word is accepted and worked on meanwhile and waits at its end
// until the held result is taken.
// cfg_we with cfg_wdata writes the reciprocal wheel base register; write it
// only while the block is idle. Reset clears the pose and history, loads the
// register default and leaves the result channel empty.
module diff_drive_odometry (
  input  logic        clk,
  input  logic        rst_n,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ddo_pkg::*;

  ddo_cmd_t cmd;
  ddo_stat_t stat;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .func         (in_ch.func),
    .left_travel  (in_ch.left_travel),
    .right_travel (in_ch.right_travel),
    .new_x        (in_ch.new_x),
    .new_y        (in_ch.new_y),
    .new_heading  (in_ch.new_heading),
    .cmd          (cmd),
    .stat         (stat),
    .pose_x       (out_ch.pose_x),
    .pose_y       (out_ch.pose_y),
    .pose_heading (out_ch.pose_heading),
    .last_linear  (out_ch.last_linear),
    .last_angular (out_ch.last_angular)
  );

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_ch.valid || out_ch.ready)
    else $error("result register overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented");

  a_commit_idle_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ch.ready)
    else $error("controller not idle after commit");

endmodule

[rtl/ddo_datapath.sv]
// Odometry datapath: pose state, shared multiplier, iterative CORDIC and result register.
module ddo_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [31:0]                             cfg_wdata,
  input  logic [1:0]                              func,
  input  logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] left_travel,
  input  logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] right_travel,
  input  logic signed [31:0]                      new_x,
  input  logic signed [31:0]                      new_y,
  input  logic signed [31:0]                      new_heading,
  input  ddo_pkg::ddo_cmd_t                       cmd,
  output ddo_pkg::ddo_stat_t                      stat,
  output logic signed [31:0]                      pose_x,
  output logic signed [31:0]                      pose_y,
  output logic signed [31:0]                      pose_heading,
  output logic signed [ddo_pkg::TRAVEL_WIDTH-1:0] last_linear,
  output logic signed [31:0]                      last_angular
);
  import ddo_pkg::*;

  localparam int TW = TRAVEL_WIDTH;

  logic [31:0] apd_r;
  logic [31:0] pos_x_r, pos_y_r, heading_r, pang_r;
  logic [TW-1:0] plin_r;
  logic [1:0] func_r;
  logic signed [TW-1:0] lin_r;
  logic signed [TW:0] diff_r;
  logic [31:0] ang_r;
  logic [31:0] nx_r, ny_r, nh_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic flip_r;
  logic [31:0] out_x_r, out_y_r, out_h_r, out_ang_r;
  logic [TW-1:0] out_lin_r;

  logic signed [TW:0] sum_in;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [CW-1:0] c_fin, s_fin, xs, ys;
  logic [4:0] iter5;
  logic signed [ZW-1:0] atan_v;
  logic [31:0] z_start;
  logic [TW-1:0] plin_nxt;
  logic [31:0] pang_nxt;

  function automatic logic [31:0] sat_step(input logic [31:0] base,
                                           input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0] d;
    logic signed [SUM_W-1:0] s;
    logic [31:0] r;
    rnd = p + (PROD_W'(1) <<< 29);
    d = rnd[30 +: SUM_W];
    s = {{(SUM_W-32){base[31]}}, base} + d;
    if (!s[SUM_W-1] && (|s[SUM_W-2:31])) begin
      r = 32'h7fff_ffff;
    end else if (s[SUM_W-1] && !(&s[SUM_W-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  assign sum_in = {left_travel[TW-1], left_travel} + {right_travel[TW-1], right_travel};
  assign c_fin = flip_r ? -cx_r : cx_r;
  assign s_fin = flip_r ? -cy_r : cy_r;
  assign iter5 = 5'(cmd.iter);
  assign xs = cx_r >>> iter5;
  assign ys = cy_r >>> iter5;
  assign atan_v = $signed({{(ZW-30){1'b0}}, atan_at(iter5)});
  assign z_start = (heading_r[31] ^ heading_r[30]) ? heading_r + 32'h8000_0000 : heading_r;

  always_comb begin
    mul_a = {{(MUL_W-TW){lin_r[TW-1]}}, lin_r};
    mul_b = c_fin;
    case (cmd.mul_sel)
      MUL_ANG: begin
        mul_a = {{(MUL_W-TW-1){diff_r[TW]}}, diff_r};
        mul_b = $signed({{(MUL_W-32){1'b0}}, apd_r});
      end
      MUL_Y: mul_b = s_fin;
      default: mul_b = c_fin;
    endcase
  end

  always_comb begin
    plin_nxt = plin_r;
    pang_nxt = pang_r;
    case (func_r)
      FUNC_UPDATE: begin
        plin_nxt = lin_r;
        pang_nxt = ang_r;
      end
      FUNC_CLEAR: begin
        plin_nxt = '0;
        pang_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apd_r <= APD_RESET;
      pos_x_r <= '0;
      pos_y_r <= '0;
      heading_r <= '0;
      plin_r <= '0;
      pang_r <= '0;
    end else begin
      if (cfg_we) begin
        apd_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        pos_x_r <= nx_r;
        pos_y_r <= ny_r;
        heading_r <= nh_r;
        plin_r <= plin_nxt;
        pang_r <= pang_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      lin_r <= sum_in[TW:1];
      diff_r <= {right_travel[TW-1], right_travel} - {left_travel[TW-1], left_travel};
      case (func)
        FUNC_SET: begin
          nx_r <= new_x;
          ny_r <= new_y;
          nh_r <= new_heading;
        end
        FUNC_CLEAR: begin
          nx_r <= '0;
          ny_r <= '0;
          nh_r <= '0;
        end
        default: begin
          nx_r <= pos_x_r;
          ny_r <= pos_y_r;
          nh_r <= heading_r;
        end
      endcase
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.cordic_init) begin
      flip_r <= heading_r[31] ^ heading_r[30];
      cz_r <= {z_start[31], z_start};
      cx_r <= CORDIC_GAIN;
      cy_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz_r[ZW-1]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_v;
      end
    end
    if (cmd.take_ang) begin
      ang_r <= prod_r[47:16];
    end
    if (cmd.acc_x) begin
      nx_r <= sat_step(pos_x_r, prod_r);
    end
    if (cmd.acc_y) begin
      ny_r <= sat_step(pos_y_r, prod_r);
      nh_r <= heading_r + ang_r;
    end
    if (cmd.commit) begin
      out_x_r <= nx_r;
      out_y_r <= ny_r;
      out_h_r <= nh_r;
      out_lin_r <= plin_nxt;
      out_ang_r <= pang_nxt;
    end
  end

  assign stat.is_update = (func_r == FUNC_UPDATE);
  assign pose_x = out_x_r;
  assign pose_y = out_y_r;
  assign pose_heading = out_h_r;
  assign last_linear = out_lin_r;
  assign last_angular = out_ang_r;

endmodule

[rtl/ddo_ctrl.sv]
// Odometry controller: sequences load, multiplies, CORDIC iterations and result handoff.
module ddo_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ddo_pkg::ddo_stat_t stat,
  output ddo_pkg::ddo_cmd_t  cmd
);
  import ddo_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_MULX = 3'd3;
  localparam logic [2:0] S_MULY = 3'd4;
  localparam logic [2:0] S_ACCY = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);

  logic [2:0] state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.iter = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.is_update) begin
          cmd.mul_en = 1'b1;
          cmd.mul_sel = MUL_ANG;
          cmd.cordic_init = 1'b1;
          cnt_nxt = '0;
          state_nxt = S_CORD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cmd.take_ang = (cnt_r == '0);
        if (cnt_r == LAST_ITER) begin
          state_nxt = S_MULX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MULX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_Y;
        cmd.acc_x = 1'b1;
        state_nxt = S_ACCY;
      end
      S_ACCY: begin
        cmd.acc_y = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
